// ----- rtl/biquad_cascade_equalizer_macros.svh -----
// ---------------------------------------------------------------------------
// Biquad cascade equalizer assertion macros
// Shared concurrent-assertion wrappers, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_EQUALIZER_MACROS_SVH
`define BIQUAD_CASCADE_EQUALIZER_MACROS_SVH

// same-cycle implication
`define BEQ_ASSERT_HOLDS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("biquad cascade equalizer: same-cycle check failed");

// next-cycle implication
`define BEQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("biquad cascade equalizer: next-cycle check failed");

`endif

// ----- rtl/beq_pkg.sv -----
// ---------------------------------------------------------------------------
// Biquad cascade equalizer package
// Word types, fixed-point constants, microcode format and program ROM.
// ---------------------------------------------------------------------------
`default_nettype none

package beq_pkg;

   localparam int MAX_STAGES_DEF = 16;
   localparam int CHANNELS_DEF   = 2;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 32;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + 2;     // five products
   localparam int FRAC_SH  = 29;              // Q3.29 coefficient fraction
   localparam int CSR_W    = 5;
   localparam int SLOTS    = 5;

   localparam logic signed [COEF_W-1:0] COEF_ONE   = 32'sh2000_0000;
   localparam logic signed [COEF_W:0]   FLAT_TOL   = 33'sd536871;
   localparam logic [ACC_W-1:0]         ROUND_HALF = ACC_W'(1) << (FRAC_SH - 1);

   localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh80_0000;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   // register indexes
   localparam logic CSR_FILTER_ENABLE = 1'b0;
   localparam logic CSR_STAGES_IN_USE = 1'b1;

   // coefficient slots
   localparam logic [2:0] SLOT_B0 = 3'd0;
   localparam logic [2:0] SLOT_B1 = 3'd1;
   localparam logic [2:0] SLOT_B2 = 3'd2;
   localparam logic [2:0] SLOT_A1 = 3'd3;
   localparam logic [2:0] SLOT_A2 = 3'd4;

   // accumulator ops
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_CLR  = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   // jump conditions
   localparam logic [2:0] COND_ALWAYS     = 3'd0;
   localparam logic [2:0] COND_CLR_LAST   = 3'd1;
   localparam logic [2:0] COND_SAMPLE     = 3'd2;
   localparam logic [2:0] COND_FILTER     = 3'd3;
   localparam logic [2:0] COND_LAST_STAGE = 3'd4;
   localparam logic [2:0] COND_OUT_FREE   = 3'd5;

   // program steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_CLR   = 4'd0;
   localparam logic [STEP_W-1:0] ST_IDLE  = 4'd1;
   localparam logic [STEP_W-1:0] ST_ROUTE = 4'd2;
   localparam logic [STEP_W-1:0] ST_MAC0  = 4'd3;
   localparam logic [STEP_W-1:0] ST_MAC1  = 4'd4;
   localparam logic [STEP_W-1:0] ST_MAC2  = 4'd5;
   localparam logic [STEP_W-1:0] ST_MAC3  = 4'd6;
   localparam logic [STEP_W-1:0] ST_MAC4  = 4'd7;
   localparam logic [STEP_W-1:0] ST_MAC5  = 4'd8;
   localparam logic [STEP_W-1:0] ST_MAC6  = 4'd9;
   localparam logic [STEP_W-1:0] ST_MAC7  = 4'd10;
   localparam logic [STEP_W-1:0] ST_EMIT  = 4'd11;

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       channel;
      logic [3:0]                 coef_stage;
      logic [2:0]                 coef_slot;
      logic signed [COEF_W-1:0]   coef_value;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       channel_out;
   } rsp_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
   } dly_type;

   // datapath control
   typedef struct packed {
      logic       take;      // req_ready
      logic       clr_wr;    // clearing pass write
      logic       coef_rd;
      logic [2:0] rd_slot;
      logic       dly_rd;
      logic       mac_en;
      logic [2:0] mac_slot;
      logic [1:0] acc_op;
      logic       commit;    // stage end
      logic       emit;
   } dp_ctrl_type;

   // status into the sequencer
   typedef struct packed {
      logic sample_go;
      logic ch_ok;
      logic out_free;
      logic clr_last;
   } seq_stat_type;

   typedef struct packed {
      logic [2:0]        cond;
      logic [STEP_W-1:0] tgt_t;
      logic [STEP_W-1:0] tgt_f;
      dp_ctrl_type       dp;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      w.cond  = COND_ALWAYS;
      w.tgt_t = step + STEP_W'(1);
      w.tgt_f = step + STEP_W'(1);
      case (step)
         ST_CLR: begin
            w.dp.clr_wr = 1'b1;
            w.cond      = COND_CLR_LAST;
            w.tgt_t     = ST_IDLE;
            w.tgt_f     = ST_CLR;
         end
         ST_IDLE: begin
            w.dp.take = 1'b1;
            w.cond    = COND_SAMPLE;
            w.tgt_t   = ST_ROUTE;
            w.tgt_f   = ST_IDLE;
         end
         ST_ROUTE: begin
            w.cond  = COND_FILTER;
            w.tgt_t = ST_MAC0;
            w.tgt_f = ST_EMIT;
         end
         ST_MAC0: begin
            w.dp.coef_rd = 1'b1;
            w.dp.rd_slot = SLOT_B0;
            w.dp.dly_rd  = 1'b1;
            w.dp.acc_op  = ACC_CLR;
         end
         ST_MAC1: begin
            w.dp.coef_rd  = 1'b1;
            w.dp.rd_slot  = SLOT_B1;
            w.dp.mac_en   = 1'b1;
            w.dp.mac_slot = SLOT_B0;
         end
         ST_MAC2: begin
            w.dp.coef_rd  = 1'b1;
            w.dp.rd_slot  = SLOT_B2;
            w.dp.mac_en   = 1'b1;
            w.dp.mac_slot = SLOT_B1;
            w.dp.acc_op   = ACC_ADD;
         end
         ST_MAC3: begin
            w.dp.coef_rd  = 1'b1;
            w.dp.rd_slot  = SLOT_A1;
            w.dp.mac_en   = 1'b1;
            w.dp.mac_slot = SLOT_B2;
            w.dp.acc_op   = ACC_ADD;
         end
         ST_MAC4: begin
            w.dp.coef_rd  = 1'b1;
            w.dp.rd_slot  = SLOT_A2;
            w.dp.mac_en   = 1'b1;
            w.dp.mac_slot = SLOT_A1;
            w.dp.acc_op   = ACC_ADD;
         end
         ST_MAC5: begin
            w.dp.mac_en   = 1'b1;
            w.dp.mac_slot = SLOT_A2;
            w.dp.acc_op   = ACC_SUB;
         end
         ST_MAC6: begin
            w.dp.acc_op = ACC_SUB;
         end
         ST_MAC7: begin
            w.dp.commit = 1'b1;
            w.cond      = COND_LAST_STAGE;
            w.tgt_t     = ST_EMIT;
            w.tgt_f     = ST_MAC0;
         end
         ST_EMIT: begin
            w.dp.emit = 1'b1;
            w.cond    = COND_OUT_FREE;
            w.tgt_t   = ST_IDLE;
            w.tgt_f   = ST_EMIT;
         end
         default: begin
            w.tgt_t = ST_IDLE;
            w.tgt_f = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/beq_datapath.sv -----
// ---------------------------------------------------------------------------
// Biquad cascade datapath
// Coefficient and delay memories, one multiplier, accumulator, saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module beq_datapath #(
   parameter int MAX_STAGES = beq_pkg::MAX_STAGES_DEF,
   parameter int CHANNELS   = beq_pkg::CHANNELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire beq_pkg::dp_ctrl_type  dp,
   input  wire logic                  req_accept,
   input  wire beq_pkg::req_word_type req_word,
   output beq_pkg::rsp_word_type      result,
   output logic                       clr_last
);

   localparam int N_COEF = MAX_STAGES * beq_pkg::SLOTS;
   localparam int N_DLY  = MAX_STAGES * CHANNELS;
   localparam int N_CLR  = (N_COEF > N_DLY) ? N_COEF : N_DLY;
   localparam int C_W    = $clog2(N_COEF);
   localparam int D_W    = (N_DLY > 1) ? $clog2(N_DLY) : 1;
   localparam int CL_W   = $clog2(N_CLR);
   localparam int CX_W   = C_W + 7;
   localparam int SW     = beq_pkg::SAMPLE_W;
   localparam int CW     = beq_pkg::COEF_W;
   localparam int PW     = beq_pkg::PROD_W;
   localparam int AW     = beq_pkg::ACC_W;
   localparam int QW     = AW - beq_pkg::FRAC_SH;

   logic signed [CW-1:0] coef_mem_ff [N_COEF];
   beq_pkg::dly_type     dly_mem_ff  [N_DLY];

   logic [CL_W-1:0]      clr_ff;
   logic [2:0]           clr_mod_ff;
   logic signed [SW-1:0] x_ff;
   logic                 ch_ff;
   logic [D_W-1:0]       d_ff;
   logic [C_W-1:0]       cbase_ff;
   logic signed [CW-1:0] coef_rd_ff;
   beq_pkg::dly_type     dly_rd_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic                 flat_ff;

   logic signed [PW-1:0] prod_in;
   logic signed [AW-1:0] acc_in;
   logic signed [SW-1:0] opnd;
   logic signed [CW-1:0] coef_ref;
   logic signed [CW:0]   diff;
   logic                 near;
   logic [AW-1:0]        rnd;
   logic [QW-1:0]        q;
   logic signed [SW-1:0] y;
   beq_pkg::dly_type     dly_new;
   logic [CX_W-1:0]      wr_addr_x;
   logic                 coef_wr;
   logic [C_W-1:0]       rd_addr;

   assign clr_last = (clr_ff == CL_W'(N_CLR - 1));

   assign coef_wr = req_accept && (req_word.op == beq_pkg::OP_COEF)
                    && (int'(req_word.coef_stage) < MAX_STAGES)
                    && (req_word.coef_slot <= beq_pkg::SLOT_A2);
   assign wr_addr_x = CX_W'(req_word.coef_stage) * CX_W'(beq_pkg::SLOTS)
                      + CX_W'(req_word.coef_slot);
   assign rd_addr   = cbase_ff + C_W'(dp.rd_slot);

   // operand and reference per slot
   always_comb begin
      case (dp.mac_slot)
         beq_pkg::SLOT_B0: opnd = x_ff;
         beq_pkg::SLOT_B1: opnd = dly_rd_ff.x1;
         beq_pkg::SLOT_B2: opnd = dly_rd_ff.x2;
         beq_pkg::SLOT_A1: opnd = dly_rd_ff.y1;
         beq_pkg::SLOT_A2: opnd = dly_rd_ff.y2;
         default:          opnd = '0;
      endcase
      coef_ref = (dp.mac_slot == beq_pkg::SLOT_B0) ? beq_pkg::COEF_ONE : '0;
   end

   assign prod_in = coef_rd_ff * opnd;
   assign diff    = $signed({coef_rd_ff[CW-1], coef_rd_ff})
                    - $signed({coef_ref[CW-1], coef_ref});
   assign near    = (diff < beq_pkg::FLAT_TOL) && (diff > -beq_pkg::FLAT_TOL);

   always_comb begin
      case (dp.acc_op)
         beq_pkg::ACC_CLR: acc_in = '0;
         beq_pkg::ACC_ADD: acc_in = acc_ff + AW'(prod_ff);
         beq_pkg::ACC_SUB: acc_in = acc_ff - AW'(prod_ff);
         default:          acc_in = acc_ff;
      endcase
   end

   // round half up, drop 29 fraction bits, saturate to 24
   assign rnd = acc_ff + beq_pkg::ROUND_HALF;
   assign q   = rnd[AW-1:beq_pkg::FRAC_SH];
   always_comb begin
      if (q[QW-1:SW-1] != {(QW-SW+1){q[QW-1]}}) begin
         y = q[QW-1] ? beq_pkg::S24_MIN : beq_pkg::S24_MAX;
      end else begin
         y = $signed(q[SW-1:0]);
      end
   end

   always_comb begin
      dly_new.x1 = x_ff;
      dly_new.x2 = dly_rd_ff.x1;
      dly_new.y1 = y;
      dly_new.y2 = dly_rd_ff.y1;
   end

   // clearing pass counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         clr_mod_ff <= '0;
      end else if (dp.clr_wr) begin
         clr_ff     <= clr_ff + CL_W'(1);
         clr_mod_ff <= (clr_mod_ff == beq_pkg::SLOT_A2) ? '0 : clr_mod_ff + 3'd1;
      end
   end

   // coefficient store
   always_ff @(posedge clock) begin
      if (dp.clr_wr && (int'(clr_ff) < N_COEF)) begin
         coef_mem_ff[C_W'(clr_ff)] <= (clr_mod_ff == beq_pkg::SLOT_B0) ?
                                      beq_pkg::COEF_ONE : '0;
      end else if (coef_wr) begin
         coef_mem_ff[C_W'(wr_addr_x)] <= req_word.coef_value;
      end
      if (dp.coef_rd) begin
         coef_rd_ff <= coef_mem_ff[rd_addr];
      end
   end

   // delay store, one word per stage and channel
   always_ff @(posedge clock) begin
      if (dp.clr_wr && (int'(clr_ff) < N_DLY)) begin
         dly_mem_ff[D_W'(clr_ff)] <= '0;
      end else if (dp.commit && !flat_ff) begin
         dly_mem_ff[d_ff] <= dly_new;
      end
      if (dp.dly_rd) begin
         dly_rd_ff <= dly_mem_ff[d_ff];
      end
   end

   // sample, addressing and MAC registers
   always_ff @(posedge clock) begin
      if (req_accept && (req_word.op == beq_pkg::OP_SAMPLE)) begin
         x_ff     <= req_word.sample_in;
         ch_ff    <= req_word.channel;
         d_ff     <= D_W'(req_word.channel);
         cbase_ff <= '0;
      end else if (dp.commit) begin
         d_ff     <= d_ff + D_W'(CHANNELS);
         cbase_ff <= cbase_ff + C_W'(beq_pkg::SLOTS);
         if (!flat_ff) begin
            x_ff <= y;
         end
      end
      if (dp.mac_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (dp.acc_op == beq_pkg::ACC_CLR) begin
         flat_ff <= 1'b1;
      end else if (dp.mac_en) begin
         flat_ff <= flat_ff && near;
      end
   end

   assign result.sample_out  = x_ff;
   assign result.channel_out = ch_ff;

endmodule

`default_nettype wire

// ----- rtl/beq_sequencer.sv -----
// ---------------------------------------------------------------------------
// Biquad cascade sequencer
// Step counter over the microcode ROM, jump conditions, stage countdown.
// ---------------------------------------------------------------------------
`default_nettype none

module beq_sequencer #(
   parameter int MAX_STAGES = beq_pkg::MAX_STAGES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire beq_pkg::seq_stat_type      stat,
   input  wire logic                       filter_enable,
   input  wire logic [beq_pkg::CSR_W-1:0]  stages_in_use,
   output beq_pkg::dp_ctrl_type            dp
);

   localparam int N_W = $clog2(MAX_STAGES + 1);
   localparam int M_W = (N_W > beq_pkg::CSR_W) ? N_W : beq_pkg::CSR_W;

   logic [beq_pkg::STEP_W-1:0] step_ff, step_in;
   logic [N_W-1:0]             rem_ff, rem_in;
   logic                       filter_on_ff, filter_on_in;
   beq_pkg::ucode_type         word;
   logic                       hit;
   logic [M_W-1:0]             n_wide;
   logic [N_W-1:0]             n_lim;

   assign word = beq_pkg::ucode_rom(step_ff);
   assign dp   = word.dp;

   assign n_wide = (M_W'(stages_in_use) > M_W'(MAX_STAGES)) ? M_W'(MAX_STAGES)
                                                            : M_W'(stages_in_use);
   assign n_lim  = N_W'(n_wide);

   always_comb begin
      case (word.cond)
         beq_pkg::COND_CLR_LAST:   hit = stat.clr_last;
         beq_pkg::COND_SAMPLE:     hit = stat.sample_go;
         beq_pkg::COND_FILTER:     hit = filter_on_ff;
         beq_pkg::COND_LAST_STAGE: hit = (rem_ff == N_W'(1));
         beq_pkg::COND_OUT_FREE:   hit = stat.out_free;
         default:                  hit = 1'b1;
      endcase
      step_in = hit ? word.tgt_t : word.tgt_f;
   end

   always_comb begin
      rem_in       = rem_ff;
      filter_on_in = filter_on_ff;
      if (stat.sample_go) begin
         rem_in       = n_lim;
         filter_on_in = filter_enable && stat.ch_ok && (n_lim != '0);
      end else if (word.dp.commit) begin
         rem_in = rem_ff - N_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= beq_pkg::ST_CLR;
         rem_ff       <= '0;
         filter_on_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rem_ff       <= rem_in;
         filter_on_ff <= filter_on_in;
      end
   end

`include "biquad_cascade_equalizer_macros.svh"

   `BEQ_ASSERT_NEXT(a_sample_routes, stat.sample_go, step_ff == beq_pkg::ST_ROUTE)
   `BEQ_ASSERT_HOLDS(a_mac_has_stage,
      (step_ff >= beq_pkg::ST_MAC0) && (step_ff <= beq_pkg::ST_MAC7), rem_ff != '0)
   `BEQ_ASSERT_NEXT(a_last_stage_emits,
      (step_ff == beq_pkg::ST_MAC7) && (rem_ff == N_W'(1)), step_ff == beq_pkg::ST_EMIT)
   `BEQ_ASSERT_NEXT(a_emit_waits,
      (step_ff == beq_pkg::ST_EMIT) && !stat.out_free, step_ff == beq_pkg::ST_EMIT)

endmodule

`default_nettype wire

// ----- rtl/biquad_cascade_equalizer.sv -----
// Usage:
// - req channel (req_valid/req_ready/req_word) carries two kinds of word: an
//   audio sample (op = sample) or a coefficient write (op = coef). A
//   coefficient write is taken in the idle step and returns nothing.
// - rsp channel (rsp_valid/rsp_ready/rsp_word) returns one word per sample.
// - csr port writes filter_enable (index 0) and stages_in_use (index 1).
// - Sample path: accept in the idle step, route, then MAC0..MAC7 for each
//   stage in use, then emit. A disabled block, zero stages in use or an
//   out-of-range channel goes from route straight to emit. Per stage, five
//   coefficient reads from the single-port store feed one 32x24
//   multiplier, then the round/saturate and delay write-back.
// - One sample is in flight at a time. req_ready is high only while the
//   sequencer sits in its idle step; a result waiting in the output
//   register does not block the next word from being taken.
// - If rsp_ready stays low, the sequencer holds in its emit step until the
//   output register frees up; no word is dropped.
// - Reset: a clearing pass walks every address of the coefficient and
//   delay stores and loads b0 = 1.0 and zeros into them; req_ready is
//   low during it, csr writes are taken as usual.
// ---------------------------------------------------------------------------
// Biquad cascade equalizer top level
// Handshakes, configuration registers and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_equalizer #(
   parameter int MAX_STAGES = beq_pkg::MAX_STAGES_DEF,
   parameter int CHANNELS   = beq_pkg::CHANNELS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire beq_pkg::req_word_type     req_word,
   // result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output beq_pkg::rsp_word_type          rsp_word,
   // configuration
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_index,
   input  wire logic [beq_pkg::CSR_W-1:0] csr_wdata
);

   logic                       filter_enable_ff;
   logic [beq_pkg::CSR_W-1:0]  stages_in_use_ff;
   logic                       rsp_valid_ff;
   beq_pkg::rsp_word_type      rsp_word_ff;

   beq_pkg::dp_ctrl_type       dp;
   beq_pkg::seq_stat_type      stat;
   beq_pkg::rsp_word_type      result;
   logic                       req_accept;
   logic                       emit;
   logic                       clr_last;

   assign req_ready  = dp.take;
   assign req_accept = req_valid && req_ready;

   // the output register is free when empty or being drained this cycle
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.sample_go = req_accept && (req_word.op == beq_pkg::OP_SAMPLE);
   assign stat.ch_ok     = (CHANNELS > 1) || !req_word.channel;
   assign stat.clr_last  = clr_last;
   assign emit           = dp.emit && stat.out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b0;
         stages_in_use_ff <= beq_pkg::CSR_W'(10);
      end else if (csr_wr_en) begin
         case (csr_index)
            beq_pkg::CSR_FILTER_ENABLE: filter_enable_ff <= csr_wdata[0];
            beq_pkg::CSR_STAGES_IN_USE: stages_in_use_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   beq_sequencer #(
      .MAX_STAGES (MAX_STAGES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .stat          (stat),
      .filter_enable (filter_enable_ff),
      .stages_in_use (stages_in_use_ff),
      .dp            (dp)
   );

   beq_datapath #(
      .MAX_STAGES (MAX_STAGES),
      .CHANNELS   (CHANNELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .dp         (dp),
      .req_accept (req_accept),
      .req_word   (req_word),
      .result     (result),
      .clr_last   (clr_last)
   );

endmodule

`default_nettype wire

// ----- tb/biquad_cascade_equalizer_tb.sv -----
// ---------------------------------------------------------------------------
// Biquad cascade equalizer testbench
// Drives sample and coefficient words through the request channel while
// random stalls on both sides, one long result hold-off and several register
// settings are applied. A bit-accurate model of the cascade predicts every
// result word, and each word that comes back is checked against it.
// ---------------------------------------------------------------------------

module biquad_cascade_equalizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD_NS   = 12;
   localparam int RESET_LEN   = 5;
   // the pause before any register write
   localparam int TAIL_CYCLES = 140;
   // hang guard limit for a run of ~930 words with gaps and stalls
   localparam int LIMIT_CYCLES = 1000000;
   localparam int HOLD_AT     = 60;     // result words before the long hold-off
   localparam int HOLD_CYCLES = 500;
   localparam int RANDOM_PER_PHASE = 150;

   // ------------------------------------------------------------------------
   // Cascade model and result tracker
   // ------------------------------------------------------------------------
   class eq_tracker;
      logic signed [beq_pkg::COEF_W-1:0]
         coef_mem [beq_pkg::MAX_STAGES_DEF*beq_pkg::SLOTS];
      logic signed [beq_pkg::SAMPLE_W-1:0]
         x_one [beq_pkg::MAX_STAGES_DEF*beq_pkg::CHANNELS_DEF];
      logic signed [beq_pkg::SAMPLE_W-1:0]
         x_two [beq_pkg::MAX_STAGES_DEF*beq_pkg::CHANNELS_DEF];
      logic signed [beq_pkg::SAMPLE_W-1:0]
         y_one [beq_pkg::MAX_STAGES_DEF*beq_pkg::CHANNELS_DEF];
      logic signed [beq_pkg::SAMPLE_W-1:0]
         y_two [beq_pkg::MAX_STAGES_DEF*beq_pkg::CHANNELS_DEF];
      logic                  filt_on;
      logic [4:0]            stage_sel;
      beq_pkg::rsp_word_type pending_out [$];
      int fail_count;
      int sample_count;
      int live_count;
      int sat_count;
      int coef_count;

      function new();
         foreach (coef_mem[i])
            coef_mem[i] = (i % beq_pkg::SLOTS == 0) ? beq_pkg::COEF_ONE : '0;
         foreach (x_one[i]) begin
            x_one[i] = '0;
            x_two[i] = '0;
            y_one[i] = '0;
            y_two[i] = '0;
         end
         filt_on      = 1'b0;
         stage_sel    = 5'd10;
         fail_count   = 0;
         sample_count = 0;
         live_count   = 0;
         sat_count    = 0;
         coef_count   = 0;
      endfunction

      function void set_reg(input logic idx, input logic [beq_pkg::CSR_W-1:0] data);
         if (idx == beq_pkg::CSR_FILTER_ENABLE) filt_on = data[0];
         else stage_sel = data;
      endfunction

      function bit tiny(input longint v);
         return ((v < 0) ? -v : v) < longint'(beq_pkg::FLAT_TOL);
      endfunction

      // a stage within tolerance of identity is skipped, delays untouched
      function bit is_flat(input int b);
         return tiny(longint'(coef_mem[b]) - longint'(beq_pkg::COEF_ONE)) &&
                tiny(longint'(coef_mem[b+1])) && tiny(longint'(coef_mem[b+2])) &&
                tiny(longint'(coef_mem[b+3])) && tiny(longint'(coef_mem[b+4]));
      endfunction

      function logic signed [beq_pkg::SAMPLE_W-1:0] run_cascade(
            input logic signed [beq_pkg::SAMPLE_W-1:0] x_in, input logic ch);
         logic signed [beq_pkg::SAMPLE_W-1:0] x;
         longint acc;
         longint y;
         int n;
         int b;
         int d;
         bit live;
         x    = x_in;
         live = 1'b0;
         if (!filt_on || int'(ch) >= beq_pkg::CHANNELS_DEF) return x;
         n = (stage_sel > beq_pkg::MAX_STAGES_DEF) ? beq_pkg::MAX_STAGES_DEF
                                                   : int'(stage_sel);
         for (int s = 0; s < n; s++) begin
            b = s * beq_pkg::SLOTS;
            d = s * beq_pkg::CHANNELS_DEF + int'(ch);
            if (is_flat(b)) continue;
            acc = longint'(coef_mem[b])   * longint'(x)
                + longint'(coef_mem[b+1]) * longint'(x_one[d])
                + longint'(coef_mem[b+2]) * longint'(x_two[d])
                - longint'(coef_mem[b+3]) * longint'(y_one[d])
                - longint'(coef_mem[b+4]) * longint'(y_two[d]);
            // round half up, floor shift back to Q1.23
            y = (acc + (longint'(1) <<< (beq_pkg::FRAC_SH - 1))) >>> beq_pkg::FRAC_SH;
            if (y > longint'(beq_pkg::S24_MAX)) begin
               y = longint'(beq_pkg::S24_MAX);
               sat_count++;
            end else if (y < longint'(beq_pkg::S24_MIN)) begin
               y = longint'(beq_pkg::S24_MIN);
               sat_count++;
            end
            x_two[d] = x_one[d];
            x_one[d] = x;
            y_two[d] = y_one[d];
            y_one[d] = beq_pkg::SAMPLE_W'(y);
            x        = beq_pkg::SAMPLE_W'(y);
            live     = 1'b1;
         end
         if (live) live_count++;
         return x;
      endfunction

      // called once per accepted request word
      function void take_word(input beq_pkg::req_word_type w);
         beq_pkg::rsp_word_type r;
         if (w.op == beq_pkg::OP_COEF) begin
            coef_count++;
            if (int'(w.coef_slot) < beq_pkg::SLOTS &&
                int'(w.coef_stage) < beq_pkg::MAX_STAGES_DEF)
               coef_mem[int'(w.coef_stage) * beq_pkg::SLOTS + int'(w.coef_slot)] =
                  w.coef_value;
            return;
         end
         sample_count++;
         r.sample_out  = run_cascade(w.sample_in, w.channel);
         r.channel_out = w.channel;
         pending_out   = {pending_out, r};
      endfunction

      // called once per accepted result word
      function void check_word(input beq_pkg::rsp_word_type got);
         beq_pkg::rsp_word_type want;
         if (pending_out.size() == 0) begin
            $error("unexpected result word: sample_out=%0d channel_out=%0d",
                   got.sample_out, got.channel_out);
            fail_count++;
            return;
         end
         want = pending_out.pop_front();
         if (got.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
            fail_count++;
         end
         if (got.channel_out !== want.channel_out) begin
            $error("channel_out: expected %0d, got %0d", want.channel_out, got.channel_out);
            fail_count++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   beq_pkg::req_word_type     req_word  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   beq_pkg::rsp_word_type     rsp_word;
   logic                      csr_wr_en = 1'b0;
   logic                      csr_index = beq_pkg::CSR_FILTER_ENABLE;
   logic [beq_pkg::CSR_W-1:0] csr_wdata = '0;

   eq_tracker mirror = new();

   logic calm = 1'b0;      // no idling on either side while set
   int   cycle_count = 0;
   int   words_out = 0;
   int   settings_run = 0;
   bit   held = 1'b0;

   always #(PERIOD_NS / 2) clock = ~clock;

   biquad_cascade_equalizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("biquad_cascade_equalizer: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Result side: check every accepted word, stall at random, and once hold
   // rsp_ready low long enough that the output register and then the input
   // back up while the sender keeps offering words.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            mirror.check_word(rsp_word);
            words_out++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held && words_out >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(!calm && $urandom_range(99) < 10);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // random don't-care content in every field; callers override what matters
   function automatic beq_pkg::req_word_type noise_word();
      beq_pkg::req_word_type w;
      w.op         = 1'($urandom);
      w.sample_in  = 24'($urandom);
      w.channel    = 1'($urandom);
      w.coef_stage = 4'($urandom);
      w.coef_slot  = 3'($urandom);
      w.coef_value = $urandom;
      return w;
   endfunction

   // one word over valid/ready; an optional idle gap goes in front of it
   task automatic send_word(input beq_pkg::req_word_type w);
      if (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      mirror.take_word(w);
   endtask

   task automatic put_sample(input logic signed [beq_pkg::SAMPLE_W-1:0] x,
                             input logic ch);
      beq_pkg::req_word_type w;
      w           = noise_word();
      w.op        = beq_pkg::OP_SAMPLE;
      w.sample_in = x;
      w.channel   = ch;
      send_word(w);
   endtask

   task automatic put_coef(input logic [3:0] stage, input logic [2:0] slot,
                           input logic signed [beq_pkg::COEF_W-1:0] value);
      beq_pkg::req_word_type w;
      w            = noise_word();
      w.op         = beq_pkg::OP_COEF;
      w.coef_stage = stage;
      w.coef_slot  = slot;
      w.coef_value = value;
      send_word(w);
   endtask

   // drop valid, wait for every expected word, then let any coefficient
   // write or sample still in the sequencer finish
   task automatic settle();
      req_valid <= 1'b0;
      while (mirror.pending_out.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // only bit 0 of the enable register counts; upper bits get noise
   task automatic set_mode(input logic en, input logic [beq_pkg::CSR_W-1:0] stages);
      logic [beq_pkg::CSR_W-1:0] en_word;
      en_word = {4'($urandom), en};
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= beq_pkg::CSR_FILTER_ENABLE;
      csr_wdata <= en_word;
      mirror.set_reg(beq_pkg::CSR_FILTER_ENABLE, en_word);
      @(posedge clock);
      csr_index <= beq_pkg::CSR_STAGES_IN_USE;
      csr_wdata <= stages;
      mirror.set_reg(beq_pkg::CSR_STAGES_IN_USE, stages);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   function automatic int span(input int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   function automatic logic signed [beq_pkg::SAMPLE_W-1:0] pick_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 3) return beq_pkg::S24_MAX;
      if (pick < 6) return beq_pkg::S24_MIN;
      if (pick < 8) return '0;
      if (pick < 10) return -24'sd1;
      if (pick < 35) return beq_pkg::SAMPLE_W'(span(4096));
      return 24'($urandom);
   endfunction

   // retune one stage with all five coefficients in order b0..a2
   task automatic load_stage(input int stage);
      logic signed [beq_pkg::COEF_W-1:0] c [beq_pkg::SLOTS];
      int kind;
      int gentle_span [beq_pkg::SLOTS];
      gentle_span = '{1 << 27, 1 << 28, 1 << 27, 1 << 27, 1 << 28};
      kind = $urandom_range(99);
      for (int i = 0; i < beq_pkg::SLOTS; i++) begin
         c[i] = (i == 0) ? beq_pkg::COEF_ONE : '0;
         if (kind < 20) begin
            c[i] += span(536870);                   // within flat tolerance
         end else if (kind < 35) begin
            // right at the flat tolerance, either side of it
            if ($urandom_range(99) < 30) c[i] += ($urandom_range(1) ? 536871 : -536871);
            else c[i] += ($urandom_range(1) ? 536870 : -536870);
         end else if (kind < 80) begin
            c[i] += span(gentle_span[i]);           // tame, mostly stable section
         end else begin
            c[i] = $urandom;                        // anything, drives saturation
         end
      end
      for (int i = 0; i < beq_pkg::SLOTS; i++) put_coef(4'(stage), 3'(i), c[i]);
   endtask

   // mostly samples, with whole-stage retunes and some stray coefficient words
   task automatic run_random(input int count);
      int k;
      int pick;
      k = 0;
      while (k < count) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            load_stage($urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
            k += beq_pkg::SLOTS;
         end else if (pick < 16) begin
            // any address, including the unused slots
            put_coef(4'($urandom), 3'($urandom), $urandom);
            k++;
         end else begin
            put_sample(pick_sample(), 1'($urandom));
            k++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      // reset settings: filter off, samples pass straight through
      put_sample(beq_pkg::S24_MAX, 1'b0);
      put_sample(beq_pkg::S24_MIN, 1'b1);
      settle();

      set_mode(1'b1, 5'd16);
      // all stages flat after reset, still a pass-through
      put_sample(beq_pkg::S24_MAX, 1'b0);
      // b0 just inside tolerance keeps stage 0 flat
      put_coef(4'd0, beq_pkg::SLOT_B0, beq_pkg::COEF_ONE + 536870);
      put_sample(-24'sd1, 1'b1);
      // unused slots are dropped
      put_coef(4'd3, 3'd5, $urandom);
      put_coef(4'd3, 3'd7, $urandom);
      put_sample(24'sd1000, 1'b0);
      // b1 just outside tolerance makes stage 1 live
      put_coef(4'd1, beq_pkg::SLOT_B1, -536871);
      put_sample(24'sd4096, 1'b0);
      put_sample(-24'sd4096, 1'b0);
      put_sample(24'sd123, 1'b1);
      // last stage at full gain: saturates both ways
      put_coef(4'd15, beq_pkg::SLOT_B0, 32'sh7FFF_FFFF);
      put_sample(beq_pkg::S24_MAX, 1'b1);
      put_sample(beq_pkg::S24_MIN, 1'b1);
      put_coef(4'd15, beq_pkg::SLOT_A1, 32'sh8000_0000);
      put_coef(4'd15, beq_pkg::SLOT_A2, 32'sh7FFF_FFFF);
      put_sample('0, 1'b0);
      put_sample(24'sd77, 1'b1);
      // zero gain in stage 0
      put_coef(4'd0, beq_pkg::SLOT_B0, '0);
      put_sample(beq_pkg::S24_MAX, 1'b0);
      // back to identity
      put_coef(4'd15, beq_pkg::SLOT_B0, beq_pkg::COEF_ONE);
      put_coef(4'd15, beq_pkg::SLOT_A1, '0);
      put_coef(4'd15, beq_pkg::SLOT_A2, '0);
      put_coef(4'd0, beq_pkg::SLOT_B0, beq_pkg::COEF_ONE);

      // random phases over a spread of register settings
      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: set_mode(1'b1, 5'd16);
            1: set_mode(1'b1, 5'($urandom_range(1, 15)));
            2: set_mode(1'b1, 5'd0);
            3: set_mode(1'b1, 5'd31);              // clamps to all stages
            4: set_mode(1'b0, 5'd16);
            default: set_mode(1'b1, 5'($urandom_range(1, 31)));
         endcase
         calm <= (p == 1);
         run_random(RANDOM_PER_PHASE);
      end
      settle();

      $display("Covered %0d samples (%0d through live stages, %0d saturated stage outputs)",
               mirror.sample_count, mirror.live_count, mirror.sat_count);
      $display("and %0d coefficient words over %0d register settings, with one long output stall.",
               mirror.coef_count, settings_run);
      if (mirror.fail_count == 0 && mirror.pending_out.size() == 0) begin
         $display("biquad_cascade_equalizer: match");
      end else begin
         $display("biquad_cascade_equalizer: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/beq_pkg.sv
rtl/beq_datapath.sv
rtl/beq_sequencer.sv
rtl/biquad_cascade_equalizer.sv
tb/biquad_cascade_equalizer_tb.sv
